>>> design/lts_pkg.sv
// Lottery scheduler package: constants, status codes, slot record, mod unit types.
// No dependencies.
`default_nettype none
package lts_pkg;
   localparam int unsigned SLOTS_DEFAULT = 64;
   localparam logic [31:0] LCG_MUL = 32'd989457;
   localparam logic [31:0] LCG_ADD = 32'd956883031;
   localparam logic [31:0] SEED_RESET = 32'd3;
   localparam logic [15:0] AGE_RESET = 16'd10000;
   localparam logic [1:0] LOTTERY_LEVEL = 2'd2;
   localparam logic [1:0] PROMOTE_LEVEL = 2'd1;
   localparam logic [1:0] RS_UNUSED = 2'd0;
   localparam logic [1:0] RS_RUNNABLE = 2'd2;
   localparam logic [1:0] ST_GRANTED = 2'd0;
   localparam logic [1:0] ST_NO_TICKETS = 2'd1;
   localparam logic [1:0] ST_NOT_RUNNABLE = 2'd2;
   localparam logic [1:0] ST_WRITE_DONE = 2'd3;
   localparam logic OP_WRITE = 1'b0;

   typedef struct packed {
      logic [1:0] run_state;
      logic [1:0] level;
      logic [15:0] tickets;
      logic [15:0] wait_count;
   } slot_type;

   // Handshake between sequencer and modulo unit.
   typedef struct packed {
      logic start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic done;
      logic [31:0] remainder;
   } mod_rsp_type;
endpackage
`default_nettype wire

>>> design/lottery_ticket_scheduler_top.sv
// Top level of the lottery ticket scheduler: age limit register and sequencer.
// Depends on lts_pkg and lts_sequencer.
`default_nettype none
// A write item is taken in the idle state and its response is registered there. A
// draw item makes one read walk over the slot memory to sum tickets, a bit-serial
// remainder, a second walk to pick the winner, and on a grant a read-modify-write
// walk that ages the other slots. All walks go through the one read port of the
// slot memory. After reset the block clears the slot memory and holds req_stall meanwhile.
module lottery_ticket_scheduler_top #(
   parameter int unsigned SLOTS = lts_pkg::SLOTS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic req_opcode,
   input wire logic [5:0] req_slot,
   input wire logic [1:0] req_run_state,
   input wire logic [1:0] req_queue_level,
   input wire logic [15:0] req_ticket_count,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_winner,
   output logic signed [23:0] rsp_draw_value,
   input wire logic csr_write,
   input wire logic [15:0] csr_wdata
);
   import lts_pkg::*;
   localparam int unsigned AW = $clog2(SLOTS);
   logic [15:0] age_limit_ff;

   // Hold the age limit
   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= AGE_RESET;
      end else if (csr_write) begin
         age_limit_ff <= csr_wdata;
      end
   end

   lts_sequencer #(.SLOTS(SLOTS), .AW(AW)) u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_slot(req_slot), .req_run_state(req_run_state),
      .req_queue_level(req_queue_level), .req_ticket_count(req_ticket_count),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_winner(rsp_winner), .rsp_draw_value(rsp_draw_value),
      .age_limit(age_limit_ff)
   );
endmodule
`default_nettype wire

>>> design/lts_slot_mem.sv
// Slot table memory: one write port, one read port, registered read data.
// Depends on lts_pkg.
`default_nettype none
module lts_slot_mem #(
   parameter int unsigned SLOTS = 64,
   parameter int unsigned AW = 6
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [AW-1:0] wr_addr,
   input wire lts_pkg::slot_type wr_data,
   input wire logic [AW-1:0] rd_addr,
   output lts_pkg::slot_type rd_data
);
   import lts_pkg::*;
   slot_type mem [SLOTS];

   // Write one entry, read one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> design/lts_mod_unit.sv
// Iterative 32-bit unsigned remainder, one quotient bit per cycle.
// Depends on lts_pkg.
`default_nettype none
module lts_mod_unit (
   input wire logic clock,
   input wire logic reset,
   input wire lts_pkg::mod_req_type req,
   output lts_pkg::mod_rsp_type rsp
);
   import lts_pkg::*;
   logic busy_ff, busy_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in, num_ff, num_in, div_ff, div_in;
   logic done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      div_in = div_ff;
      done_in = 1'b0;
      trial = {rem_ff, num_ff[31]} - {1'b0, div_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         num_in = req.dividend;
         div_in = req.divisor;
      end else if (busy_ff) begin
         // Shift in one dividend bit, subtract when it fits
         rem_in = trial[32] ? {rem_ff[30:0], num_ff[31]} : trial[31:0];
         num_in = {num_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      div_ff <= div_in;
   end

   assign rsp.done = done_ff;
   assign rsp.remainder = rem_ff;
endmodule
`default_nettype wire

>>> design/lts_sequencer.sv
// Draw and write sequencer: walks the slot memory, drives the modulo unit.
// Depends on lts_pkg, lts_slot_mem, lts_mod_unit.
`default_nettype none
module lts_sequencer #(
   parameter int unsigned SLOTS = 64,
   parameter int unsigned AW = 6
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic req_opcode,
   input wire logic [5:0] req_slot,
   input wire logic [1:0] req_run_state,
   input wire logic [1:0] req_queue_level,
   input wire logic [15:0] req_ticket_count,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_winner,
   output logic signed [23:0] rsp_draw_value,
   input wire logic [15:0] age_limit
);
   import lts_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_CLEAR = 8'b0000_0010,
      S_SUM = 8'b0000_0100,
      S_MOD = 8'b0000_1000,
      S_PICK = 8'b0001_0000,
      S_CHECK = 8'b0010_0000,
      S_AGE = 8'b0100_0000,
      S_OUT = 8'b1000_0000
   } state_type;

   localparam logic [AW:0] LAST = (AW + 1)'(SLOTS - 1);
   localparam logic [AW:0] DEPTH = (AW + 1)'(SLOTS);

   state_type state_ff, state_in;
   logic [AW:0] addr_ff, addr_in;      // issued read address
   logic rvalid_ff, rvalid_in;        // read data in flight
   logic [AW-1:0] raddr_ff, raddr_in;  // address of data now on rd_data
   logic [31:0] seed_ff, seed_in;
   logic [21:0] total_ff, total_in;
   logic [21:0] run_ff, run_in;
   logic signed [23:0] draw_ff, draw_in;
   logic [AW-1:0] win_ff, win_in;
   logic found_ff, found_in;
   logic [1:0] status_ff, status_in;
   logic [31:0] prod_ff, prod_in;
   logic outv_ff, outv_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   slot_type wr_data, rd_data;
   mod_req_type mreq;
   mod_rsp_type mrsp;
   logic [32:0] seed_abs;
   logic signed [32:0] rem_s;
   logic [15:0] wait_inc;

   lts_slot_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );
   lts_mod_unit u_mod (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   assign req_stall = (state_ff != S_IDLE) || outv_ff;
   assign rsp_valid = outv_ff;
   assign rsp_status = status_ff;
   assign rsp_winner = 6'(win_ff);
   assign rsp_draw_value = draw_ff;
   assign rd_addr = addr_ff[AW-1:0];
   assign seed_abs = seed_ff[31] ? 33'(-{1'b1, seed_ff}) : {1'b0, seed_ff};
   assign wait_inc = (rd_data.wait_count == 16'hFFFF) ? 16'hFFFF
                                                     : rd_data.wait_count + 16'd1;

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      rvalid_in = 1'b0;
      raddr_in = addr_ff[AW-1:0];
      seed_in = seed_ff;
      total_in = total_ff;
      run_in = run_ff;
      draw_in = draw_ff;
      win_in = win_ff;
      found_in = found_ff;
      status_in = status_ff;
      prod_in = prod_ff;
      outv_in = outv_ff && rsp_stall;
      wr_en = 1'b0;
      wr_addr = raddr_ff;
      wr_data = rd_data;
      mreq.start = 1'b0;
      mreq.dividend = seed_abs[31:0];
      mreq.divisor = {10'd0, total_ff};
      rem_s = '0;
      unique case (state_ff)
         // Clear the table after reset, one entry a cycle
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = addr_ff[AW-1:0];
            wr_data = '0;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            addr_in = '0;
            if (req_valid && !req_stall) begin
               if (req_opcode == OP_WRITE) begin
                  if (9'(req_slot) < 9'(SLOTS)) begin
                     wr_en = 1'b1;
                     wr_addr = AW'(req_slot);
                     wr_data.run_state = req_run_state;
                     wr_data.level = req_queue_level;
                     wr_data.tickets = req_ticket_count;
                     wr_data.wait_count = '0;
                  end
                  status_in = ST_WRITE_DONE;
                  win_in = '0;
                  draw_in = '0;
                  outv_in = 1'b1;
               end else begin
                  prod_in = seed_ff * LCG_MUL;
                  total_in = '0;
                  addr_in = '0;
                  state_in = S_SUM;
                  seed_in = seed_ff;
               end
            end
         end
         // Sum level-2 tickets; first cycle finishes the seed update
         S_SUM: begin
            if (addr_ff == '0 && !rvalid_ff) begin
               seed_in = prod_ff + LCG_ADD;
            end
            if (addr_ff != DEPTH) begin
               addr_in = addr_ff + 1'b1;
               rvalid_in = 1'b1;
            end
            if (rvalid_ff && rd_data.level == LOTTERY_LEVEL) begin
               total_in = total_ff + 22'(rd_data.tickets);
            end
            if (rvalid_ff && addr_ff == DEPTH) begin
               if (total_in == '0) begin
                  status_in = ST_NO_TICKETS;
                  win_in = '0;
                  draw_in = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_MOD;
               end
               addr_in = '0;
            end
         end
         S_MOD: begin
            if (!mrsp.done) begin
               mreq.start = (addr_ff == '0);
               addr_in = {{AW{1'b0}}, 1'b1};
            end else begin
               rem_s = seed_ff[31] ? -$signed({1'b0, mrsp.remainder})
                                   : $signed({1'b0, mrsp.remainder});
               draw_in = 24'(rem_s + 33'sd1);
               run_in = '0;
               found_in = 1'b0;
               win_in = '0;
               addr_in = '0;
               state_in = S_PICK;
            end
         end
         // Walk for the first level-2 slot whose running sum reaches the draw
         S_PICK: begin
            if (addr_ff != DEPTH && !found_ff) begin
               addr_in = addr_ff + 1'b1;
               rvalid_in = 1'b1;
            end
            if (rvalid_ff && !found_ff && rd_data.level == LOTTERY_LEVEL) begin
               run_in = run_ff + 22'(rd_data.tickets);
               if ($signed({2'b00, run_in}) >= draw_ff) begin
                  found_in = 1'b1;
                  win_in = raddr_ff;
               end
            end
            if (!rvalid_ff && (found_ff || addr_ff == DEPTH)) begin
               addr_in = {1'b0, win_in};
               state_in = S_CHECK;
               found_in = 1'b0;
            end
         end
         // Read the winner's run state
         S_CHECK: begin
            if (!found_ff) begin
               found_in = 1'b1;
               rvalid_in = 1'b1;
            end else if (rvalid_ff) begin
               if (rd_data.run_state != RS_RUNNABLE) begin
                  status_in = ST_NOT_RUNNABLE;
                  state_in = S_OUT;
               end else begin
                  status_in = ST_GRANTED;
                  addr_in = '0;
                  state_in = S_AGE;
               end
            end
         end
         // Age every other used slot: read, modify, write back
         S_AGE: begin
            if (addr_ff != DEPTH) begin
               addr_in = addr_ff + 1'b1;
               rvalid_in = 1'b1;
            end
            if (rvalid_ff && rd_data.run_state != RS_UNUSED && raddr_ff != win_ff) begin
               wr_en = 1'b1;
               if (wait_inc >= age_limit) begin
                  wr_data.level = PROMOTE_LEVEL;
                  wr_data.wait_count = '0;
               end else begin
                  wr_data.wait_count = wait_inc;
               end
            end
            if (rvalid_ff && addr_ff == DEPTH) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            outv_in = 1'b1;
            addr_in = '0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         rvalid_ff <= 1'b0;
         outv_ff <= 1'b0;
         found_ff <= 1'b0;
         seed_ff <= SEED_RESET;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         rvalid_ff <= rvalid_in;
         outv_ff <= outv_in;
         found_ff <= found_in;
         seed_ff <= seed_in;
      end
      raddr_ff <= raddr_in;
      total_ff <= total_in;
      run_ff <= run_in;
      draw_ff <= draw_in;
      win_ff <= win_in;
      status_ff <= status_in;
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire
